FILE: rtl/fractal_value_noise_top_defines.svh
// Assertion macros shared by the noise block.
`ifndef FRACTAL_VALUE_NOISE_TOP_DEFINES_SVH
`define FRACTAL_VALUE_NOISE_TOP_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define FVN_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define FVN_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fvn_pkg.sv
package fvn_pkg;

  localparam int MaxSide = 64;
  localparam int MaxOctaves = 8;
  localparam int CoordW = $clog2(MaxSide);
  localparam int AddrW = 2 * CoordW;
  localparam int SideW = CoordW + 1;
  localparam int OctW = 4;
  localparam int KW = $clog2(MaxOctaves);

  localparam logic [1:0] CfgWidth = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgOctaves = 2'd2;

  localparam logic ActLoad = 1'b0;
  localparam logic ActQuery = 1'b1;

  // Sum width: octave value < 2^(8+2K), shifted by up to n-1 more bits, n terms.
  localparam int SumW = 8 + 3 * MaxOctaves + 2;
  // Numerator of the final division carries the extra factor of 256.
  localparam int NumW = SumW + 8;
  localparam int DenW = 2 * MaxOctaves;
  localparam int QCntW = $clog2(NumW + 1);

  typedef struct packed {
    logic        action;
    logic [5:0]  pos_x;
    logic [5:0]  pos_y;
    logic [7:0]  base_sample;
  } in_item_t;

  typedef struct packed {
    logic [15:0] noise_value;
    logic        range_error;
  } out_item_t;

  typedef struct packed {
    logic [1:0] index;
    logic [6:0] data;
  } cfg_item_t;

  // Control between the sequencer and the divider.
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/fvn_divider.sv
module fvn_divider (
  input  logic             clk,
  input  logic             rst,
  input  fvn_pkg::div_req_t req,
  output fvn_pkg::div_rsp_t rsp
);
  import fvn_pkg::*;

  logic             busy;
  logic             done;
  logic [QCntW-1:0] count;
  logic [NumW-1:0]  num;
  logic [DenW-1:0]  den;
  logic [DenW:0]    rem;
  logic [NumW-1:0]  quot;
  logic [DenW:0]    trial;
  logic [DenW:0]    rem_shift;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_shift = {rem[DenW-1:0], num[NumW-1]};
    trial = rem_shift - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= QCntW'(NumW);
        num <= req.num;
        den <= req.den;
        rem <= '0;
        quot <= '0;
      end else if (busy) begin
        num <= {num[NumW-2:0], 1'b0};
        if (!trial[DenW]) begin
          rem <= trial;
          quot <= {quot[NumW-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quot <= {quot[NumW-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == QCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot[15:0];

endmodule

FILE: rtl/fractal_value_noise_top.sv
// Channel   Direction  Payload      Transfer when
// in        input      in_item_t    in_valid && in_ready
// out       output     out_item_t   out_valid && out_ready
// cfg       input      cfg_item_t   cfg_valid && cfg_ready
//
// A load is written to the grid when it is taken and leaves the block idle. A
// query is accepted, then runs each octave as four grid reads through the
// single memory port, two blend steps and one accumulate step, then starts
// and runs the 42 steps of the bit-serial divider, and then offers the result
// until it is taken. A query outside the grid goes straight to the result.
// Reset is synchronous; it returns the sequencer to idle and sets width and
// height to 64 and octaves to 4; the grid is not cleared. in_ready is low
// while an item is at work or a result waits.
module fractal_value_noise_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fvn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fvn_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  fvn_pkg::cfg_item_t cfg_data
);
  import fvn_pkg::*;
  `include "fractal_value_noise_top_defines.svh"

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRd00  = 4'd1;
  localparam logic [3:0] StRd10  = 4'd2;
  localparam logic [3:0] StRd01  = 4'd3;
  localparam logic [3:0] StRd11  = 4'd4;
  localparam logic [3:0] StTop   = 4'd5;
  localparam logic [3:0] StBot   = 4'd6;
  localparam logic [3:0] StAcc   = 4'd7;
  localparam logic [3:0] StDiv   = 4'd8;
  localparam logic [3:0] StWait  = 4'd9;
  localparam logic [3:0] StOut   = 4'd10;

  logic [3:0] state;

  // Configuration registers.
  logic [6:0] grid_width;
  logic [6:0] grid_height;
  logic [3:0] octave_count;
  logic [SideW-1:0] w_eff;
  logic [SideW-1:0] h_eff;
  logic [KW:0]      n_eff;

  always_comb begin
    if (grid_width == 7'd0) w_eff = SideW'(1);
    else if (grid_width > 7'(MaxSide)) w_eff = SideW'(MaxSide);
    else w_eff = SideW'(grid_width);
    if (grid_height == 7'd0) h_eff = SideW'(1);
    else if (grid_height > 7'(MaxSide)) h_eff = SideW'(MaxSide);
    else h_eff = SideW'(grid_height);
    if (octave_count == 4'd0) n_eff = (KW+1)'(1);
    else if (octave_count > 4'(MaxOctaves)) n_eff = (KW+1)'(MaxOctaves);
    else n_eff = (KW+1)'(octave_count);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 7'd64;
      grid_height <= 7'd64;
      octave_count <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_data.index)
        CfgWidth:   grid_width <= cfg_data.data;
        CfgHeight:  grid_height <= cfg_data.data;
        CfgOctaves: octave_count <= cfg_data.data[3:0];
        default: ;
      endcase
    end
  end

  // Base grid memory, one port, registered read.
  logic [7:0]       grid_mem [MaxSide*MaxSide];
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_q;
  logic             mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_addr] <= in_data.base_sample;
    mem_q <= grid_mem[mem_addr];
  end

  // Query registers.
  logic [CoordW-1:0] qx, qy;
  logic [KW-1:0]     k;
  logic [CoordW-1:0] x0, y0, x1, y1;
  logic [CoordW+1:0] a, b, pma, pmb;
  logic [7:0]        s00, s10, s01;
  logic [16:0]       top, bot;
  logic [SumW-1:0]   sum;
  logic [CoordW-1:0] xpm, ypm;
  logic [CoordW-1:0] xpm_next, ypm_next;
  logic [CoordW:0]   x1s, y1s, xpm2, ypm2;
  logic              range_error;
  logic [15:0]       noise_value;

  // Corner coordinates of the current octave. xpm and ypm hold the period
  // modulo the width and height; they double with each octave. Since x0 is
  // below the width and xpm is too, one compare and subtract wraps x1.
  logic [CoordW+1:0] p_val;
  always_comb begin
    p_val = (CoordW+2)'(1) << k;
    x0 = (qx >> k) << k;
    y0 = (qy >> k) << k;
    x1s = (CoordW+1)'(x0) + (CoordW+1)'(xpm);
    if (x1s >= w_eff) x1s = x1s - w_eff;
    y1s = (CoordW+1)'(y0) + (CoordW+1)'(ypm);
    if (y1s >= h_eff) y1s = y1s - h_eff;
    x1 = CoordW'(x1s);
    y1 = CoordW'(y1s);
    xpm2 = {xpm, 1'b0};
    if (xpm2 >= w_eff) xpm2 = xpm2 - w_eff;
    ypm2 = {ypm, 1'b0};
    if (ypm2 >= h_eff) ypm2 = ypm2 - h_eff;
    xpm_next = CoordW'(xpm2);
    ypm_next = CoordW'(ypm2);
    a = (CoordW+2)'(qx - x0);
    b = (CoordW+2)'(qy - y0);
    pma = p_val - a;
    pmb = p_val - b;
  end

  // Shared multiplier: one 8x8 blend pair or a 17x8 blend pair per step.
  logic [16:0] mul_a1, mul_a2;
  logic [CoordW+1:0] mul_b1, mul_b2;
  logic [24:0] mul_sum;
  assign mul_sum = 25'(mul_a1 * mul_b1) + 25'(mul_a2 * mul_b2);

  always_comb begin
    mem_we = 1'b0;
    mem_addr = {in_data.pos_x, in_data.pos_y};
    mul_a1 = '0; mul_a2 = '0; mul_b1 = '0; mul_b2 = '0;
    unique case (state)
      StIdle: mem_we = in_valid && in_ready && (in_data.action == ActLoad);
      StRd00: mem_addr = {x0, y0};
      StRd10: mem_addr = {x1, y0};
      StRd01: mem_addr = {x0, y1};
      StRd11: mem_addr = {x1, y1};
      StTop: begin
        // Hold the last corner so its sample is still on the port next step.
        mem_addr = {x1, y1};
        mul_a1 = 17'(s00); mul_b1 = pma; mul_a2 = 17'(s10); mul_b2 = a;
      end
      StBot: begin
        mul_a1 = 17'(s01); mul_b1 = pma; mul_a2 = 17'(mem_q); mul_b2 = a;
      end
      StAcc: begin
        mul_a1 = top; mul_b1 = pmb; mul_a2 = bot; mul_b2 = b;
      end
      default: ;
    endcase
  end

  // Divider hookup. Denominator 2^(n-1) * (2^n - 1).
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [DenW-1:0] den;
  always_comb begin
    den = ((DenW'(1) << n_eff) - DenW'(1)) << (n_eff - 1'b1);
    div_req.start = (state == StDiv);
    div_req.num = {sum, 8'd0};
    div_req.den = den;
  end

  fvn_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      unique case (state)
        StIdle: begin
          if (in_valid && in_ready && in_data.action == ActQuery) begin
            qx <= in_data.pos_x;
            qy <= in_data.pos_y;
            k <= '0;
            sum <= '0;
            xpm <= (w_eff == SideW'(1)) ? '0 : CoordW'(1);
            ypm <= (h_eff == SideW'(1)) ? '0 : CoordW'(1);
            if ((SideW)'(in_data.pos_x) >= w_eff || (SideW)'(in_data.pos_y) >= h_eff) begin
              range_error <= 1'b1;
              noise_value <= '0;
              state <= StOut;
            end else begin
              range_error <= 1'b0;
              state <= StRd00;
            end
          end
        end
        StRd00: state <= StRd10;
        StRd10: begin s00 <= mem_q; state <= StRd01; end
        StRd01: begin s10 <= mem_q; state <= StRd11; end
        StRd11: begin s01 <= mem_q; state <= StTop; end
        StTop:  begin top <= mul_sum[16:0]; state <= StBot; end
        StBot:  begin bot <= mul_sum[16:0]; state <= StAcc; end
        StAcc: begin
          // Octave k is weighted by shifting left by n-1-k.
          sum <= sum + (SumW'(mul_sum) << (KW'(n_eff - 1'b1) - k));
          if ((KW+1)'(k) == n_eff - 1'b1) state <= StDiv;
          else begin
            k <= k + 1'b1;
            xpm <= xpm_next;
            ypm <= ypm_next;
            state <= StRd00;
          end
        end
        StDiv: state <= StWait;
        StWait: begin
          if (div_rsp.done) begin
            noise_value <= div_rsp.quot;
            state <= StOut;
          end
        end
        StOut: if (out_ready) state <= StIdle;
        default: state <= StIdle;
      endcase
    end
  end

  assign in_ready = (state == StIdle);
  assign out_valid = (state == StOut);
  assign out_data.noise_value = noise_value;
  assign out_data.range_error = range_error;

  // A range error always reports a zero value.
  `FVN_ASSERT_IMPL(a_err_zero, clk, rst, out_valid && out_data.range_error,
    out_data.noise_value == 16'd0, "range error with nonzero value")
  // The divider only finishes while the sequencer waits for it.
  `FVN_ASSERT_IMPL(a_div_wait, clk, rst, div_rsp.done, state == StWait,
    "divider finished outside wait")
  // A stalled result stays on the port.
  `FVN_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_data), "result changed while stalled")

endmodule

FILE: bench/fractal_value_noise_top_tb.sv
module fractal_value_noise_top_tb;
  import fvn_pkg::*;

  localparam int FillSide = 24;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_item_t cfg_data;

  fractal_value_noise_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // The bench keeps its own copy of the grid and of the three registers.
  // Every query's expected result is worked out when the item is queued;
  // the driver never runs ahead of a configuration change, so the register
  // copy always matches what the block sees at the time of the transfer.
  logic [7:0] grid_copy [MaxSide*MaxSide];
  logic [6:0] width_reg;
  logic [6:0] height_reg;
  logic [3:0] octaves_reg;

  in_item_t  pending_items [$];
  out_item_t noise_expected [$];
  int        mismatch_count;
  int        send_idle_pct;
  int        recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A generous fixed ceiling for roughly 1500 items at up to 8 octaves, with
  // ample room for the time that stalls add.
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Exact multi-octave value noise: every octave is held over 256*P*P, all
  // are summed over a common denominator, and one floor division ends it.
  function automatic out_item_t predict_noise(input logic [5:0] px, input logic [5:0] py);
    out_item_t r;
    int unsigned w, h, n, k, p, x0, y0, x1, y1, a, b;
    longint unsigned top, bot, oct, total, den;
    w = (width_reg == 0) ? 1 : (width_reg > MaxSide) ? MaxSide : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MaxSide) ? MaxSide : height_reg;
    n = (octaves_reg == 0) ? 1 : (octaves_reg > MaxOctaves) ? MaxOctaves : octaves_reg;
    r = '0;
    if (px >= w || py >= h) begin
      r.range_error = 1'b1;
      return r;
    end
    total = 0;
    for (k = 0; k < n; k++) begin
      p = 1 << k;
      x0 = (px >> k) << k;
      y0 = (py >> k) << k;
      x1 = (x0 + p) % w;
      y1 = (y0 + p) % h;
      a = px - x0;
      b = py - y0;
      top = grid_copy[x0*MaxSide+y0] * (p - a) + grid_copy[x1*MaxSide+y0] * a;
      bot = grid_copy[x0*MaxSide+y1] * (p - a) + grid_copy[x1*MaxSide+y1] * a;
      oct = top * (p - b) + bot * b;
      total += oct << (n - 1 - k);
    end
    den = (64'd1 << (n - 1)) * ((64'd1 << n) - 1);
    r.noise_value = 16'((total * 256) / den);
    return r;
  endfunction

  // Queue one item and, for a query, its expected result.
  task automatic queue_item(input logic act, input logic [5:0] px, input logic [5:0] py,
                            input logic [7:0] smp);
    in_item_t it;
    it.action = act;
    it.pos_x = px;
    it.pos_y = py;
    it.base_sample = smp;
    pending_items = {pending_items, it};
    if (act == ActLoad) grid_copy[px*MaxSide+py] = smp;
    else noise_expected = {noise_expected, predict_noise(px, py)};
  endtask

  // Driver: keeps valid high until the transfer, then offers the next item
  // or idles at the configured rate.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (noise_expected.size() == 0) begin
          report_mismatch("unexpected result", out_data.noise_value, 0);
        end else begin
          if (out_data.noise_value !== noise_expected[0].noise_value)
            report_mismatch("noise_value", out_data.noise_value,
                            noise_expected[0].noise_value);
          if (out_data.range_error !== noise_expected[0].range_error)
            report_mismatch("range_error", out_data.range_error,
                            noise_expected[0].range_error);
          void'(noise_expected.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Waits until every queued item has been sent and every result has come,
  // then lets a load that may still be in flight finish.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || noise_expected.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_data.index <= idx;
    cfg_data.data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CfgWidth) width_reg = val;
    else if (idx == CfgHeight) height_reg = val;
    else octaves_reg = val[3:0];
  endtask

  // Fills every entry that a query can reach under the settings used below:
  // a square at the origin plus the whole first row and first column.
  task automatic fill_grid();
    for (int x = 0; x < FillSide; x++)
      for (int y = 0; y < FillSide; y++)
        queue_item(ActLoad, 6'(x), 6'(y), 8'($urandom));
    for (int i = FillSide; i < MaxSide; i++) begin
      queue_item(ActLoad, 6'(i), 6'd0, 8'($urandom));
      queue_item(ActLoad, 6'd0, 6'(i), 8'($urandom));
    end
  endtask

  // Mostly queries inside the grid, with some outside and some reloads.
  task automatic random_items(input int count);
    int unsigned w, h, sel;
    w = (width_reg == 0) ? 1 : (width_reg > MaxSide) ? MaxSide : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MaxSide) ? MaxSide : height_reg;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 15)
        queue_item(ActLoad, 6'($urandom), 6'($urandom), 8'($urandom));
      else if (sel < 25)
        queue_item(ActQuery, 6'($urandom), 6'($urandom), 8'($urandom));
      else
        queue_item(ActQuery, 6'($urandom_range(w - 1)), 6'($urandom_range(h - 1)),
                   8'($urandom));
    end
  endtask

  task automatic set_config(input logic [6:0] w, input logic [6:0] h, input logic [6:0] n);
    drain();
    write_reg(CfgWidth, w);
    write_reg(CfgHeight, h);
    write_reg(CfgOctaves, n);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    width_reg = 7'd64;
    height_reg = 7'd64;
    octaves_reg = 4'd4;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Loading the reachable part of the grid makes every later query well
    // defined.
    fill_grid();
    // Directed part: origin, all-ones sample, queries near the origin.
    queue_item(ActLoad, 6'd1, 6'd1, 8'hFF);
    queue_item(ActLoad, 6'd0, 6'd0, 8'h00);
    queue_item(ActQuery, 6'd0, 6'd0, 8'hFF);
    queue_item(ActQuery, 6'd1, 6'd1, 8'h00);
    queue_item(ActQuery, 6'd13, 6'd14, 8'hAA);
    queue_item(ActQuery, 6'd5, 6'd6, 8'h55);
    drain();

    // Small grid with a period longer than it, and out-of-range queries.
    set_config(7'd3, 7'd5, 7'd8);
    queue_item(ActQuery, 6'd2, 6'd4, 8'h00);
    queue_item(ActQuery, 6'd3, 6'd0, 8'h00);
    queue_item(ActQuery, 6'd0, 6'd5, 8'h00);
    queue_item(ActQuery, 6'd63, 6'd63, 8'h00);
    queue_item(ActLoad, 6'd40, 6'd50, 8'h81);
    // Register values of zero and beyond the limits are clamped.
    set_config(7'd0, 7'd127, 7'd0);
    queue_item(ActQuery, 6'd0, 6'd63, 8'h00);
    queue_item(ActQuery, 6'd1, 6'd10, 8'h00);
    set_config(7'd127, 7'd0, 7'd15);
    queue_item(ActQuery, 6'd63, 6'd0, 8'h00);
    queue_item(ActQuery, 6'd62, 6'd1, 8'h00);
    set_config(7'd1, 7'd1, 7'd1);
    queue_item(ActQuery, 6'd0, 6'd0, 8'h00);

    // Random phases; each sets a configuration and one of four idling mixes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      case (ph)
        0: set_config(7'(FillSide), 7'(FillSide), 7'd8);
        1: set_config(7'd1, 7'd64, 7'd1);
        2: set_config(7'd64, 7'd1, 7'd3);
        default: set_config(7'($urandom_range(1, FillSide)), 7'($urandom_range(1, FillSide)),
                            7'($urandom_range(1, 8)));
      endcase
      random_items(100);
    end
    drain();
    repeat (150) @(posedge clk);
    if (mismatch_count == 0 && noise_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
